// ===== hdl/lru_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared sizes and the control structures passed between the scan unit,
// the frame store and the sequencer.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int PAGE_BITS  = 8;
    localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int RANK_W     = FRAME_W;
    localparam int AGE_W      = FRAME_W + 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int CFG_W      = 5;
    localparam int FAULT_W    = 16;
    localparam int FRAMES_RST = 3;

    // Running result of the frame scan.
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] hit_slot;
        logic               empty;
        logic [FRAME_W-1:0] empty_slot;
        logic [RANK_W-1:0]  max_rank;
        logic [FRAME_W-1:0] max_slot;
    } t_scan;

    // Update request from the sequencer to the frame store.
    typedef struct packed {
        logic                 en;
        logic                 fill;
        logic                 wr_page;
        logic [FRAME_W-1:0]   slot;
        logic [PAGE_BITS-1:0] page;
    } t_upd;

endpackage

// ===== hdl/lru_scan_unit.sv =====
// ----------------------------------------------------------------------------
// LRU scan unit
// Compares one frame per cycle against the referenced page and folds the
// outcome into the running hit, first-empty and oldest-frame results.
// ----------------------------------------------------------------------------
module lru_scan_unit import lru_pkg::*; (
    input  logic [FRAME_W-1:0]   i_idx,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_full,
    input  logic [RANK_W-1:0]    i_rank,
    input  logic [PAGE_BITS-1:0] i_target,
    input  t_scan                i_acc,
    output t_scan                o_acc
);

    t_scan base;

    always_comb begin
        // The first frame starts a fresh accumulation.
        if (i_idx == '0) begin
            base          = '0;
            base.max_rank = i_rank;
        end else begin
            base = i_acc;
        end
        o_acc = base;
        if (!base.hit && i_full && (i_page == i_target)) begin
            o_acc.hit      = 1'b1;
            o_acc.hit_slot = i_idx;
        end
        if (!base.empty && !i_full) begin
            o_acc.empty      = 1'b1;
            o_acc.empty_slot = i_idx;
        end
        if (i_rank > base.max_rank) begin
            o_acc.max_rank = i_rank;
            o_acc.max_slot = i_idx;
        end
    end

endmodule

// ===== hdl/lru_frame_store.sv =====
// ----------------------------------------------------------------------------
// LRU frame store
// Holds the page, full flag and recency rank of every frame, with one read
// port and an update that makes one frame most recent.
// ----------------------------------------------------------------------------
module lru_frame_store import lru_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [FRAME_W-1:0]   i_rd_idx,
    output logic [PAGE_BITS-1:0] o_rd_page,
    output logic                 o_rd_full,
    output logic [RANK_W-1:0]    o_rd_rank,
    input  t_upd                 i_upd
);

    logic [PAGE_BITS-1:0] r_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_full;
    logic [RANK_W-1:0]    r_rank [MAX_FRAMES];
    logic [AGE_W-1:0]     old_age;

    assign o_rd_page = r_page[i_rd_idx];
    assign o_rd_full = r_full[i_rd_idx];
    assign o_rd_rank = r_rank[i_rd_idx];

    // A newly filled frame counts as older than every full frame.
    assign old_age = i_upd.fill ? AGE_W'(MAX_FRAMES) : AGE_W'(r_rank[i_upd.slot]);

    always_ff @(posedge i_clk) begin
        if (i_upd.en && i_upd.wr_page) begin
            r_page[i_upd.slot] <= i_upd.page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            for (int g = 0; g < MAX_FRAMES; g++) begin
                r_rank[g] <= '0;
            end
        end else if (i_upd.en) begin
            for (int g = 0; g < MAX_FRAMES; g++) begin
                if (FRAME_W'(g) == i_upd.slot) begin
                    r_rank[g] <= '0;
                end else if (r_full[g] && (AGE_W'(r_rank[g]) < old_age) &&
                             (r_rank[g] != RANK_W'(MAX_FRAMES - 1))) begin
                    r_rank[g] <= r_rank[g] + RANK_W'(1);
                end
            end
            if (i_upd.fill) begin
                r_full[i_upd.slot] <= 1'b1;
            end
        end
    end

endmodule

// ===== hdl/lru_page_replacement_unit.sv =====
// An accepted reference is scanned one frame per cycle over N frames, where N
// is the active frame count (1..16); the chosen frame is then updated and the
// result registered, the update waiting while the previous result awaits transfer.
// References are taken only in the idle state, after the update of the last;
// a new reference may be taken while the previous result waits for transfer.
// Reset (synchronous, active low): all frames empty, ranks and fault count
// zero, frames_in_use set to 3, no result pending.
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Sequencer that scans the active frames through a shared compare unit,
// then updates the chosen frame and the recency ranks together in its update state.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit import lru_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PAGE_BITS-1:0] i_page_number,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic [FRAME_W-1:0]   o_frame_slot,
    output logic                 o_evicted_valid,
    output logic [PAGE_BITS-1:0] o_evicted_page,
    output logic [FAULT_W-1:0]   o_fault_total
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CFG_W-1:0]     r_frames_in_use;
    logic [CNT_W-1:0]     r_active, n_active;
    logic [FRAME_W-1:0]   r_idx;
    logic [PAGE_BITS-1:0] r_page;
    t_scan                r_scan, n_scan;
    logic [FAULT_W-1:0]   r_fault_cnt;
    logic                 r_out_valid;
    logic                 r_hit, r_ev_valid;
    logic [FRAME_W-1:0]   r_slot;
    logic [PAGE_BITS-1:0] r_ev_page;

    logic [FRAME_W-1:0]   rd_idx;
    logic [PAGE_BITS-1:0] rd_page;
    logic                 rd_full;
    logic [RANK_W-1:0]    rd_rank;
    t_upd                 upd;
    logic                 accept, last, out_free, evict;
    logic [FRAME_W-1:0]   sel_slot;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign last     = ((CNT_W'(r_idx) + CNT_W'(1)) == r_active);
    assign out_free = !r_out_valid || i_ready;
    assign evict    = !r_scan.hit && !r_scan.empty;
    assign sel_slot = r_scan.hit ? r_scan.hit_slot :
                      (r_scan.empty ? r_scan.empty_slot : r_scan.max_slot);
    assign rd_idx   = (r_state == S_UPDATE) ? sel_slot : r_idx;

    always_comb begin
        if (r_frames_in_use == '0) begin
            n_active = CNT_W'(1);
        end else if (32'(r_frames_in_use) > MAX_FRAMES) begin
            n_active = CNT_W'(MAX_FRAMES);
        end else begin
            n_active = CNT_W'(r_frames_in_use);
        end
    end

    lru_scan_unit u_scan (
        .i_idx    (r_idx),
        .i_page   (rd_page),
        .i_full   (rd_full),
        .i_rank   (rd_rank),
        .i_target (r_page),
        .i_acc    (r_scan),
        .o_acc    (n_scan)
    );

    always_comb begin
        upd         = '0;
        upd.en      = (r_state == S_UPDATE) && out_free;
        upd.fill    = !r_scan.hit && r_scan.empty;
        upd.wr_page = !r_scan.hit;
        upd.slot    = sel_slot;
        upd.page    = r_page;
    end

    lru_frame_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (rd_idx),
        .o_rd_page (rd_page),
        .o_rd_full (rd_full),
        .o_rd_rank (rd_rank),
        .i_upd     (upd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (last) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frames_in_use <= CFG_W'(FRAMES_RST);
            r_fault_cnt     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_data;
            end
            if (upd.en) begin
                r_out_valid <= 1'b1;
                if (!r_scan.hit && (r_fault_cnt != '1)) begin
                    r_fault_cnt <= r_fault_cnt + FAULT_W'(1);
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page   <= i_page_number;
            r_active <= n_active;
            r_idx    <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan <= n_scan;
            if (!last) r_idx <= r_idx + FRAME_W'(1);
        end
        if (upd.en) begin
            r_hit      <= r_scan.hit;
            r_slot     <= sel_slot;
            r_ev_valid <= evict;
            r_ev_page  <= evict ? rd_page : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_total   = r_fault_cnt;

`ifndef NO_ASSERTIONS
    // The scan index never runs past the active frame count.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_active))
        else $error("scan index beyond active frames");

    // A hit never reports an evicted page.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit reported with an eviction");

    // The evicted page reads zero when nothing was evicted.
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page not zero without eviction");

    // The fault count changes only on the update cycle.
    a_fault_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!upd.en) |=> $stable(r_fault_cnt))
        else $error("fault count changed outside an update");

    // A pending result that is not taken blocks the update.
    a_update_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_out_valid && !i_ready) |=> (r_state == S_UPDATE))
        else $error("update overran an untaken result");
`endif

endmodule
